>>> hw/rtl/ddft_pkg.sv
// Package for the direct-form DFT block: field widths, command/status types,
// controller state encoding and the Q1.15 twiddle lookup.
// No dependencies.
package ddft_pkg;

  localparam int POINTS_MAX_DEF = 64;
  localparam int SAMPLE_W       = 16;
  localparam int BIN_W          = 23;
  localparam int IDX_W          = 6;   // bin index / counters, up to 64 points
  localparam int LOG_W          = 3;
  localparam int ACC_W          = 40;  // 64 x 2^31 worst case plus sign
  localparam int FRAC_W         = 15;
  localparam int PHASE_W        = 6;   // twiddle table is 64 points
  localparam logic [LOG_W-1:0] LOG_RESET = 3'd6;
  localparam logic [LOG_W-1:0] LOG_MIN   = 3'd2;
  localparam logic [LOG_W-1:0] TABLE_LOG = 3'd6;
  localparam logic [PHASE_W-1:0] QUARTER = 6'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } ddft_state_e;

  // Controller to datapath
  typedef struct packed {
    logic             wr;       // store one sample word
    logic [IDX_W-1:0] wr_addr;
    logic             issue;    // one MAC step for (k, j)
    logic             first_j;
    logic             last_j;
    logic             last_k;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] j;
    logic [LOG_W-1:0] lp;       // clamped log2 length
  } ddft_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pipe_busy;
  } ddft_stat_t;

  typedef logic signed [SAMPLE_W-1:0] quarter_t [0:16];

  // round(32768*sin(2*pi*i/64)), peak held at 32767
  localparam quarter_t QUARTER_SINE = '{
    16'sd0, 16'sd3212, 16'sd6393, 16'sd9512, 16'sd12540, 16'sd15447,
    16'sd18205, 16'sd20788, 16'sd23170, 16'sd25330, 16'sd27246, 16'sd28899,
    16'sd30274, 16'sd31357, 16'sd32138, 16'sd32610, 16'sd32767
  };

  function automatic logic signed [SAMPLE_W-1:0] sine64(input logic [PHASE_W-1:0] m);
    logic [4:0]                idx;
    logic signed [SAMPLE_W-1:0] v;
    idx = m[4] ? (5'd16 - {1'b0, m[3:0]}) : {1'b0, m[3:0]};
    v   = QUARTER_SINE[idx];
    return m[5] ? -v : v;
  endfunction

endpackage

>>> hw/rtl/ddft_ctrl.sv
// Controller for the direct-form DFT: frame fill count, length register,
// bin/tap sequencing. Depends on ddft_pkg.
module ddft_ctrl #(
  parameter int POINTS_MAX = ddft_pkg::POINTS_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             cfg_we_i,
  input  logic [ddft_pkg::LOG_W-1:0]       cfg_data_i,
  input  ddft_pkg::ddft_stat_t             stat_i,
  output ddft_pkg::ddft_cmd_t              cmd_o,
  output logic                             busy_o
);
  import ddft_pkg::*;

  localparam logic [LOG_W-1:0] PMAX_LOG = LOG_W'($clog2(POINTS_MAX));

  ddft_state_e      state_q, state_d;
  logic [LOG_W-1:0] log_q, log_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [LOG_W-1:0] lp_eff;
  logic [IDX_W:0]   n_full;
  logic [IDX_W-1:0] nm1;
  logic             accept;

  always_comb begin
    lp_eff = log_q;
    if (lp_eff < LOG_MIN) begin
      lp_eff = LOG_MIN;
    end
    if (lp_eff > PMAX_LOG) begin
      lp_eff = PMAX_LOG;
    end
    n_full = (IDX_W+1)'(1) << lp_eff;
    nm1    = IDX_W'(n_full - (IDX_W+1)'(1));
  end

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (cnt_q == nm1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((j_q == nm1) && (k_q == nm1)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd_o         = '0;
    cmd_o.wr_addr = cnt_q;
    cmd_o.k       = k_q;
    cmd_o.j       = j_q;
    cmd_o.lp      = lp_eff;
    cmd_o.first_j = (j_q == '0);
    cmd_o.last_j  = (j_q == nm1);
    cmd_o.last_k  = (k_q == nm1);
    cnt_d = cnt_q;
    k_d   = k_q;
    j_d   = j_q;
    log_d = log_q;
    case (state_q)
      ST_IDLE: begin
        k_d = '0;
        j_d = '0;
        if (accept) begin
          cmd_o.wr = 1'b1;
          cnt_d    = (cnt_q == nm1) ? '0 : cnt_q + IDX_W'(1);
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (j_q == nm1) begin
          j_d = '0;
          k_d = k_q + IDX_W'(1);
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
      end
      default: begin
      end
    endcase
    // a length change drops the partial frame
    if (cfg_we_i) begin
      log_d = cfg_data_i;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      log_q   <= LOG_RESET;
      cnt_q   <= '0;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      log_q   <= log_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      j_q     <= j_d;
    end
  end

endmodule

>>> hw/rtl/ddft_dp.sv
// Datapath for the direct-form DFT: sample store, twiddle phase and lookup,
// complex multiply, accumulate and bin output register. Depends on ddft_pkg.
module ddft_dp #(
  parameter int POINTS_MAX = ddft_pkg::POINTS_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ddft_pkg::ddft_cmd_t                  cmd_i,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] sample_real_i,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] sample_imag_i,
  output ddft_pkg::ddft_stat_t                 stat_o,
  output logic                                 bin_valid_o,
  output logic signed [ddft_pkg::BIN_W-1:0]    bin_real_o,
  output logic signed [ddft_pkg::BIN_W-1:0]    bin_imag_o,
  output logic [ddft_pkg::IDX_W-1:0]           bin_index_o,
  output logic                                 last_bin_o
);
  import ddft_pkg::*;

  localparam int ADDR_W = $clog2(POINTS_MAX);

  logic [2*SAMPLE_W-1:0] store_mem [POINTS_MAX];
  logic [2*SAMPLE_W-1:0] rd_q;

  // twiddle phase, table units
  logic [PHASE_W-1:0] phase_q, phase_d, phase_use, step;
  logic signed [SAMPLE_W-1:0] cos_q, sin_q;

  // stage tags
  logic             v1_q, v2_q;
  logic             first1_q, first2_q, lastj1_q, lastj2_q, lastk1_q, lastk2_q;
  logic [IDX_W-1:0] k1_q, k2_q;

  logic signed [SAMPLE_W-1:0]   xr, xi;
  logic signed [2*SAMPLE_W-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic signed [ACC_W-1:0]      sum_re, sum_im;
  logic signed [ACC_W-1:0]      acc_re_q, acc_re_d, acc_im_q, acc_im_d;

  logic                    bin_valid_q;
  logic signed [BIN_W-1:0] bin_real_q, bin_imag_q;
  logic [IDX_W-1:0]        bin_index_q;
  logic                    last_bin_q;

  // sample store
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      store_mem[cmd_i.wr_addr[ADDR_W-1:0]] <= {sample_imag_i, sample_real_i};
    end
    rd_q <= store_mem[cmd_i.j[ADDR_W-1:0]];
  end

  // phase advances by k*(64/n) each tap, wrapping mod 64
  always_comb begin
    step      = PHASE_W'(cmd_i.k) << (TABLE_LOG - cmd_i.lp);
    phase_use = cmd_i.first_j ? '0 : phase_q;
    phase_d   = phase_use + step;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      phase_q <= phase_d;
      cos_q   <= sine64(phase_use + QUARTER);
      sin_q   <= sine64(phase_use);
    end
  end

  assign xr = rd_q[SAMPLE_W-1:0];
  assign xi = rd_q[2*SAMPLE_W-1:SAMPLE_W];

  always_ff @(posedge clk_i) begin
    p_rc_q <= xr * cos_q;
    p_is_q <= xi * sin_q;
    p_ic_q <= xi * cos_q;
    p_rs_q <= xr * sin_q;
  end

  always_comb begin
    sum_re   = ACC_W'(p_rc_q) + ACC_W'(p_is_q);
    sum_im   = ACC_W'(p_ic_q) - ACC_W'(p_rs_q);
    acc_re_d = first2_q ? sum_re : acc_re_q + sum_re;
    acc_im_d = first2_q ? sum_im : acc_im_q + sum_im;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
    // floor shift by 15, keep bin width
    bin_real_q  <= acc_re_d[FRAC_W+BIN_W-1:FRAC_W];
    bin_imag_q  <= acc_im_d[FRAC_W+BIN_W-1:FRAC_W];
    bin_index_q <= k2_q;
    last_bin_q  <= lastk2_q;
    k1_q        <= cmd_i.k;
    k2_q        <= k1_q;
    first1_q    <= cmd_i.first_j;
    first2_q    <= first1_q;
    lastj1_q    <= cmd_i.last_j;
    lastj2_q    <= lastj1_q;
    lastk1_q    <= cmd_i.last_k;
    lastk2_q    <= lastk1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      bin_valid_q <= 1'b0;
    end else begin
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      bin_valid_q <= v2_q && lastj2_q;
    end
  end

  assign stat_o.pipe_busy = v1_q || v2_q;
  assign bin_valid_o      = bin_valid_q;
  assign bin_real_o       = bin_real_q;
  assign bin_imag_o       = bin_imag_q;
  assign bin_index_o      = bin_index_q;
  assign last_bin_o       = last_bin_q;

endmodule

>>> hw/rtl/direct_dft.sv
// Direct-form DFT over n = 2^log_points complex Q1.15 samples (4..POINTS_MAX).
// A word that does not complete a frame is only stored and busy stays low. The
// word completing a frame starts the MACs for all (k, j) pairs (one complex MAC
// per cycle, one shared complex MAC unit); bin k is strobed after its last tap
// passes the product and output registers; busy holds until the pipe drains.
// Reset (async, active low) clears control state and sets log_points to 6.
module direct_dft #(
  parameter int POINTS_MAX = ddft_pkg::POINTS_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration: log2 of transform length
  input  logic                                 log_points_we_i,
  input  logic [ddft_pkg::LOG_W-1:0]           log_points_i,
  // sample words
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] sample_real_i,
  input  logic signed [ddft_pkg::SAMPLE_W-1:0] sample_imag_i,
  // bin words, one per cycle of bin_valid_o
  output logic                                 bin_valid_o,
  output logic signed [ddft_pkg::BIN_W-1:0]    bin_real_o,
  output logic signed [ddft_pkg::BIN_W-1:0]    bin_imag_o,
  output logic [ddft_pkg::IDX_W-1:0]           bin_index_o,
  output logic                                 last_bin_o
);
  import ddft_pkg::*;

  ddft_cmd_t  cmd;
  ddft_stat_t stat;

  // Controller: counts samples into the frame; once full it walks k then j,
  // issuing one tap per cycle, and waits for the MAC pipe to drain.
  // A log_points write clears the partial frame.
  ddft_ctrl #(
    .POINTS_MAX (POINTS_MAX)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cfg_we_i   (log_points_we_i),
    .cfg_data_i (log_points_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // Datapath: sample RAM read and twiddle lookup (phase accumulated by
  // k*64/n per tap), 4 registered 16x16 products, 40-bit accumulators,
  // then floor >> 15 into the bin output register, strobed valid on the last tap.
  ddft_dp #(
    .POINTS_MAX (POINTS_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_real_i (sample_real_i),
    .sample_imag_i (sample_imag_i),
    .stat_o        (stat),
    .bin_valid_o   (bin_valid_o),
    .bin_real_o    (bin_real_o),
    .bin_imag_o    (bin_imag_o),
    .bin_index_o   (bin_index_o),
    .last_bin_o    (last_bin_o)
  );

endmodule
